// ===== design/hmr_pkg.sv =====
// Shared constants and types for the histogram max-rectangle core.
`default_nettype none
package hmr_pkg;

   localparam int MAX_BARS    = 1024;
   localparam int HEIGHT_BITS = 32;
   localparam int IN_H_BITS   = 32;
   localparam int AREA_BITS   = 42;

   localparam int ADDR_BITS  = $clog2(MAX_BARS);
   localparam int CNT_BITS   = $clog2(MAX_BARS + 1);
   localparam int STK_H_BITS = (HEIGHT_BITS < IN_H_BITS) ? HEIGHT_BITS : IN_H_BITS;
   localparam int MUL_BITS   = STK_H_BITS + CNT_BITS;
   localparam int PROD_BITS  = (MUL_BITS > AREA_BITS) ? MUL_BITS : AREA_BITS + 1;

   typedef struct packed {
      logic [STK_H_BITS-1:0] height;
      logic [ADDR_BITS-1:0]  start;
   } stack_entry_type;

   typedef struct packed {
      logic                  valid;
      logic [STK_H_BITS-1:0] height;
      logic [CNT_BITS-1:0]   width;
   } score_req_type;

endpackage
`default_nettype wire

// ===== design/hmr_stack_mem.sv =====
// Stack storage: one write port, one read port with registered read data.
`default_nettype none
module hmr_stack_mem (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [hmr_pkg::ADDR_BITS-1:0] wr_addr,
   input  wire hmr_pkg::stack_entry_type    wr_data,
   input  wire logic                        rd_en,
   input  wire logic [hmr_pkg::ADDR_BITS-1:0] rd_addr,
   output hmr_pkg::stack_entry_type         rd_data
);
   import hmr_pkg::*;

   stack_entry_type mem [MAX_BARS];
   stack_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/hmr_area_unit.sv =====
// Area scoring: registered multiply, saturate, and running maximum.
`default_nettype none
module hmr_area_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hmr_pkg::score_req_type        score,
   input  wire logic                          clear,
   output logic [hmr_pkg::AREA_BITS-1:0]      best_area,
   output logic                               busy
);
   import hmr_pkg::*;

   logic                  prod_valid_ff, prod_valid_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [AREA_BITS-1:0]  best_ff, best_in;
   logic [AREA_BITS-1:0]  area_c;

   always_comb begin
      prod_valid_in = score.valid;
      prod_in       = PROD_BITS'(score.height) * PROD_BITS'(score.width);
      // saturate anything that does not fit the area field
      if (|prod_ff[PROD_BITS-1:AREA_BITS]) begin
         area_c = '1;
      end else begin
         area_c = prod_ff[AREA_BITS-1:0];
      end
      best_in = best_ff;
      if (clear) begin
         best_in = '0;
      end else if (prod_valid_ff && (area_c > best_ff)) begin
         best_in = area_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         best_ff       <= '0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         best_ff       <= best_in;
      end
      prod_ff <= prod_in;
   end

   assign best_area = best_ff;
   assign busy      = prod_valid_ff;

endmodule
`default_nettype wire

// ===== design/histogram_max_rectangle_core.sv =====
// Top level of the streaming largest-rectangle-under-histogram core.
//
//   channel | direction | words                          | handshake
//   --------+-----------+--------------------------------+-------------------
//   req_    | in        | req_height, req_last_bar       | req_valid/req_ready
//   rsp_    | out       | rsp_max_area, rsp_overflow     | rsp_valid/rsp_ready
//
// A bar is accepted, pops each stack entry at least as tall as itself, and is
// then pushed. The next top entry is read from the stack memory in the same
// cycle as the pop and used straight from the registered read port, so pops
// follow back to back. Every bar is pushed once and popped at most once. A
// bar past the bar limit is accepted and dropped without a push.
// The final bar then flushes every remaining entry, finds the stack empty,
// and then loads the result word.
// Synchronous reset clears the control state;
// the stack memory needs no clearing since only entries below the depth are
// read. A result word waiting on rsp_ready does not block new bars; only a
// second result stalls until the first is taken.
`default_nettype none
module histogram_max_rectangle_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [hmr_pkg::IN_H_BITS-1:0]  req_height,
   input  wire logic                           req_last_bar,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [hmr_pkg::AREA_BITS-1:0]       rsp_max_area,
   output logic                                rsp_overflow
);
   import hmr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    depth_ff, depth_in;
   logic [CNT_BITS-1:0]    pos_ff, pos_in;
   logic                   too_many_ff, too_many_in;
   logic                   flush_ff, flush_in;
   logic                   last_ff, last_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [STK_H_BITS-1:0]  cur_h_ff, cur_h_in;
   logic [STK_H_BITS-1:0]  cmp_h_ff, cmp_h_in;
   logic [ADDR_BITS-1:0]   start_ff, start_in;
   logic [STK_H_BITS-1:0]  top_h_ff, top_h_in;
   logic [ADDR_BITS-1:0]   top_s_ff, top_s_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AREA_BITS-1:0]   rsp_area_ff, rsp_area_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic [STK_H_BITS-1:0]  top_h_c;
   logic [ADDR_BITS-1:0]   top_s_c;
   logic [CNT_BITS-1:0]    depth_less2_c;

   logic                   mem_wr_en;
   logic [ADDR_BITS-1:0]   mem_wr_addr;
   stack_entry_type        mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_BITS-1:0]   mem_rd_addr;
   stack_entry_type        mem_rd_data;

   score_req_type          score;
   logic                   best_clear;
   logic [AREA_BITS-1:0]   best_area;
   logic                   area_busy;

   hmr_stack_mem u_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hmr_area_unit u_area (
      .clock     (clock),
      .reset     (reset),
      .score     (score),
      .clear     (best_clear),
      .best_area (best_area),
      .busy      (area_busy)
   );

   // forward the freshly read top entry straight from the read port
   assign top_h_c       = rd_pend_ff ? mem_rd_data.height : top_h_ff;
   assign top_s_c       = rd_pend_ff ? mem_rd_data.start  : top_s_ff;
   assign depth_less2_c = depth_ff - CNT_BITS'(2);

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      pos_in       = pos_ff;
      too_many_in  = too_many_ff;
      flush_in     = flush_ff;
      last_in      = last_ff;
      rd_pend_in   = 1'b0;
      cur_h_in     = cur_h_ff;
      cmp_h_in     = cmp_h_ff;
      start_in     = start_ff;
      top_h_in     = top_h_c;
      top_s_in     = top_s_c;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_area_in  = rsp_area_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      mem_wr_en    = 1'b0;
      mem_wr_addr  = depth_ff[ADDR_BITS-1:0];
      mem_wr_data  = '{height: cur_h_ff, start: start_ff};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = depth_less2_c[ADDR_BITS-1:0];

      score.valid  = 1'b0;
      score.height = top_h_c;
      score.width  = pos_ff - CNT_BITS'(top_s_c);
      best_clear   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (pos_ff < CNT_BITS'(MAX_BARS)) begin
                  cur_h_in = req_height[STK_H_BITS-1:0];
                  cmp_h_in = req_height[STK_H_BITS-1:0];
                  start_in = pos_ff[ADDR_BITS-1:0];
                  flush_in = 1'b0;
                  last_in  = req_last_bar;
                  state_in = ST_POP;
               end else begin
                  // drop the surplus bar, but still flush on the last one
                  too_many_in = 1'b1;
                  if (req_last_bar) begin
                     cmp_h_in = '0;
                     flush_in = 1'b1;
                     state_in = ST_POP;
                  end
               end
            end
         end
         ST_POP: begin
            if ((depth_ff != '0) && (top_h_c >= cmp_h_ff)) begin
               // pop the top, score it, and fetch the entry below
               score.valid = 1'b1;
               start_in    = top_s_c;
               depth_in    = depth_ff - CNT_BITS'(1);
               if (depth_ff > CNT_BITS'(1)) begin
                  mem_rd_en  = 1'b1;
                  rd_pend_in = 1'b1;
               end
            end else if (!flush_ff) begin
               // push the new bar with its inherited start
               mem_wr_en = 1'b1;
               top_h_in  = cur_h_ff;
               top_s_in  = start_ff;
               depth_in  = depth_ff + CNT_BITS'(1);
               pos_in    = pos_ff + CNT_BITS'(1);
               if (last_ff) begin
                  flush_in = 1'b1;
                  cmp_h_in = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!area_busy && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = best_area;
               rsp_ovf_in   = too_many_ff;
               best_clear   = 1'b1;
               depth_in     = '0;
               pos_in       = '0;
               too_many_in  = 1'b0;
               flush_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         pos_ff       <= '0;
         too_many_ff  <= 1'b0;
         flush_ff     <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         pos_ff       <= pos_in;
         too_many_ff  <= too_many_in;
         flush_ff     <= flush_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      cur_h_ff    <= cur_h_in;
      cmp_h_ff    <= cmp_h_in;
      start_ff    <= start_in;
      top_h_ff    <= top_h_in;
      top_s_ff    <= top_s_in;
      rsp_area_ff <= rsp_area_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_area = rsp_area_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire
